/* design/ftb_pkg.sv */
// Types and constants shared by the token bucket limiter.
// No dependencies.
`default_nettype none
package ftb_pkg;

    localparam int NUM_BUCKETS = 4;

    typedef struct packed {
        logic [1:0]  command;
        logic [47:0] now_ns;
        logic [1:0]  flow_class;
        logic [31:0] token_cost;
        logic [6:0]  buffer_occupancy;
        logic [15:0] free_block_count;
    } in_item_t;

    typedef struct packed {
        logic       admitted;
        logic [2:0] verdict;
        logic [2:0] pressure_level;
    } out_item_t;

    localparam logic [1:0] CMD_CHECK  = 2'd0;
    localparam logic [1:0] CMD_BP     = 2'd1;
    localparam logic [1:0] CMD_REFILL = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] CLS_READ  = 2'd0;
    localparam logic [1:0] CLS_WRITE = 2'd1;
    localparam logic [1:0] CLS_GC    = 2'd2;
    localparam logic [1:0] CLS_ADMIN = 2'd3;

    localparam logic [2:0] V_ADMIT    = 3'd0;
    localparam logic [2:0] V_BP       = 3'd1;
    localparam logic [2:0] V_TOKENS   = 3'd2;
    localparam logic [2:0] V_DISABLED = 3'd3;
    localparam logic [2:0] V_NONE     = 3'd4;

    localparam logic [2:0] REG_ENABLE      = 3'd0;
    localparam logic [2:0] REG_CLASS_RATE  = 3'd1;
    localparam logic [2:0] REG_CLASS_BURST = 3'd2;
    localparam logic [2:0] REG_GC_RATE     = 3'd3;
    localparam logic [2:0] REG_GC_BURST    = 3'd4;

    localparam logic [31:0] RESET_TOKENS = 32'd1000000;
    localparam logic [23:0] RESET_RATE   = 24'd1000000;

    // 1e9 = 2^9 * 1953125: drop 9 bits, then divide by the odd part
    localparam int          NS_SHIFT    = 9;
    localparam logic [20:0] DIV_ODD     = 21'd1953125;
    // 63-bit dividend padded to six digits of 11 bits
    localparam int          DIG_W       = 11;
    localparam int          NUM_W       = 66;
    // floor(2^52 / 1953125); the estimate is low by at most one
    localparam logic [31:0] DIV_RECIP   = 32'd2305843009;
    localparam int          RECIP_SHIFT = 52;
    localparam logic [3:0]  DIV_LAST    = 4'd11;

    localparam logic [6:0]  OCC_CRIT = 7'd95;
    localparam logic [6:0]  OCC_HIGH = 7'd85;
    localparam logic [6:0]  OCC_MED  = 7'd70;
    localparam logic [6:0]  OCC_LOW  = 7'd50;
    localparam logic [15:0] FREE_CRIT = 16'd2;
    localparam logic [15:0] FREE_HIGH = 16'd5;
    localparam logic [15:0] FREE_MED  = 16'd10;
    localparam logic [15:0] FREE_LOW  = 16'd20;

    typedef struct packed {
        logic       load;
        logic       bp_update;
        logic       set_res;
        logic [2:0] res_code;
        logic       mul_lo;
        logic       mul_hi;
        logic       div_est;
        logic       div_fix;
        logic       update;
        logic       deduct;
        logic       out_load;
        logic [1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] flow_class;
        logic       enabled;
        logic       throttled;
        logic       skip;
    } dp_status_t;

endpackage
`default_nettype wire

/* design/ftb_dp.sv */
// Datapath: config registers, buckets, multiply, divide-by-1e9 and result.
// Depends on ftb_pkg.
`default_nettype none
module ftb_dp import ftb_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire in_item_t   in_item,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      status,
    output out_item_t       out_item
);

    logic        enable_reg;
    logic [23:0] class_rate_reg, gc_rate_reg;
    logic [31:0] class_burst_reg, gc_burst_reg;
    logic [31:0] tokens_reg [NUM_BUCKETS];
    logic [47:0] last_reg   [NUM_BUCKETS];
    logic [2:0]  pressure_reg;
    in_item_t    item_reg;
    logic [47:0] prod_reg;
    logic [23:0] el_hi_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [20:0] rem_reg;
    logic [31:0] part_reg;
    logic [10:0] qest_reg;
    logic        res_adm_reg;
    logic [2:0]  res_verdict_reg;
    out_item_t   out_reg;

    logic [23:0] rate_sel;
    logic [31:0] cap_sel;
    logic [47:0] last_sel, el;
    logic [31:0] tok_sel;
    logic [71:0] sum72;
    logic [31:0] part;
    logic [63:0] recip_prod;
    logic [31:0] fix_diff;
    logic        fix_ge;
    logic [63:0] tok_sum;
    logic [2:0]  level;
    logic        throttled;

    assign rate_sel = (cmd.idx == CLS_GC) ? gc_rate_reg : class_rate_reg;
    assign cap_sel  = (cmd.idx == CLS_GC) ? gc_burst_reg : class_burst_reg;
    assign last_sel = last_reg[cmd.idx];
    assign tok_sel  = tokens_reg[cmd.idx];
    assign el       = item_reg.now_ns - last_sel;
    assign sum72    = {24'd0, prod_reg} +
                      {({24'd0, rate_sel} * {24'd0, el_hi_reg}), 24'd0};
    assign part       = {rem_reg, num_reg[NUM_W-1 -: DIG_W]};
    assign recip_prod = {32'd0, part} * {32'd0, DIV_RECIP};
    assign fix_diff   = part_reg - ({21'd0, qest_reg} * {11'd0, DIV_ODD});
    assign fix_ge     = fix_diff >= {11'd0, DIV_ODD};
    assign tok_sum  = {32'd0, tok_sel} + 64'(quot_reg);

    always_comb
    begin
        if (item_reg.buffer_occupancy >= OCC_CRIT || item_reg.free_block_count < FREE_CRIT)
            level = 3'd4;
        else if (item_reg.buffer_occupancy >= OCC_HIGH || item_reg.free_block_count < FREE_HIGH)
            level = 3'd3;
        else if (item_reg.buffer_occupancy >= OCC_MED || item_reg.free_block_count < FREE_MED)
            level = 3'd2;
        else if (item_reg.buffer_occupancy >= OCC_LOW || item_reg.free_block_count < FREE_LOW)
            level = 3'd1;
        else
            level = 3'd0;
    end

    always_comb
    begin
        case (pressure_reg)
            3'd1:    throttled = (item_reg.flow_class == CLS_GC);
            3'd2:    throttled = (item_reg.flow_class == CLS_WRITE) ||
                                 (item_reg.flow_class == CLS_GC);
            3'd3,
            3'd4:    throttled = (item_reg.flow_class != CLS_ADMIN);
            default: throttled = 1'b0;
        endcase
    end

    assign status.command    = item_reg.command;
    assign status.flow_class = item_reg.flow_class;
    assign status.enabled    = enable_reg;
    assign status.throttled  = throttled;
    assign status.skip       = item_reg.now_ns <= last_sel;
    assign out_item          = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b1;
            class_rate_reg  <= RESET_RATE;
            gc_rate_reg     <= RESET_RATE;
            class_burst_reg <= RESET_TOKENS;
            gc_burst_reg    <= RESET_TOKENS;
            pressure_reg    <= 3'd0;
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                tokens_reg[i] <= RESET_TOKENS;
                last_reg[i]   <= 48'd0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENABLE:      enable_reg      <= cfg_data[0];
                    REG_CLASS_RATE:  class_rate_reg  <= cfg_data[23:0];
                    REG_CLASS_BURST: class_burst_reg <= cfg_data;
                    REG_GC_RATE:     gc_rate_reg     <= cfg_data[23:0];
                    REG_GC_BURST:
                    begin
                        gc_burst_reg <= cfg_data;
                        if (tokens_reg[CLS_GC] > cfg_data)
                            tokens_reg[CLS_GC] <= cfg_data;
                    end
                    default: ;
                endcase
            end
            if (cmd.bp_update)
                pressure_reg <= level;
            if (cmd.update && quot_reg != '0)
            begin
                tokens_reg[cmd.idx] <= (tok_sum > {32'd0, cap_sel}) ? cap_sel : tok_sum[31:0];
                last_reg[cmd.idx]   <= item_reg.now_ns;
            end
            if (cmd.deduct && tok_sel >= item_reg.token_cost)
                tokens_reg[cmd.idx] <= tok_sel - item_reg.token_cost;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
        if (cmd.mul_lo)
        begin
            prod_reg  <= {24'd0, rate_sel} * {24'd0, el[23:0]};
            el_hi_reg <= el[47:24];
        end
        // drop the power-of-two part of 1e9 before the long division
        if (cmd.mul_hi)
        begin
            num_reg <= {3'd0, sum72[71:NS_SHIFT]};
            rem_reg <= '0;
        end
        // estimate one 11-bit quotient digit by reciprocal multiply
        if (cmd.div_est)
        begin
            part_reg <= part;
            qest_reg <= recip_prod[RECIP_SHIFT +: DIG_W];
            num_reg  <= {num_reg[NUM_W-DIG_W-1:0], {DIG_W{1'b0}}};
        end
        // bump the digit by one when the remainder is still too large
        if (cmd.div_fix)
        begin
            quot_reg <= {quot_reg[NUM_W-DIG_W-1:0],
                         fix_ge ? 11'(qest_reg + 11'd1) : qest_reg};
            rem_reg  <= fix_ge ? 21'(fix_diff - {11'd0, DIV_ODD}) : fix_diff[20:0];
        end
        if (cmd.set_res)
        begin
            res_adm_reg     <= (cmd.res_code == V_DISABLED);
            res_verdict_reg <= cmd.res_code;
        end
        if (cmd.deduct)
        begin
            res_adm_reg     <= tok_sel >= item_reg.token_cost;
            res_verdict_reg <= (tok_sel >= item_reg.token_cost) ? V_ADMIT : V_TOKENS;
        end
        if (cmd.out_load)
        begin
            out_reg.admitted       <= res_adm_reg;
            out_reg.verdict        <= res_verdict_reg;
            out_reg.pressure_level <= pressure_reg;
        end
    end

endmodule
`default_nettype wire

/* design/ftb_ctrl.sv */
// Controller: sequences decide, per-bucket refill, deduct and output.
// Depends on ftb_pkg.
`default_nettype none
module ftb_ctrl import ftb_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_MLO    = 8'b0000_0100,
        S_MHI    = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_UPD    = 8'b0010_0000,
        S_CHK    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    state_t     after_bucket;
    logic [1:0] after_idx;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // advance to the next bucket; after the last one, on to the deduct step for a check or to done for a refill
    always_comb
    begin
        if (idx_reg == 2'(NUM_BUCKETS - 1))
        begin
            after_bucket = (status.command == CMD_CHECK) ? S_CHK : S_DONE;
            after_idx    = status.flow_class;
        end
        else
        begin
            after_bucket = S_MLO;
            after_idx    = idx_reg + 2'd1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.idx        = idx_reg;
        cmd.res_code   = V_NONE;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                idx_next    = 2'd0;
                cmd.set_res = 1'b1;
                case (status.command)
                    CMD_CHECK:
                    begin
                        if (!status.enabled)
                        begin
                            cmd.res_code = V_DISABLED;
                            state_next   = S_DONE;
                        end
                        else if (status.throttled)
                        begin
                            cmd.res_code = V_BP;
                            state_next   = S_DONE;
                        end
                        else
                            state_next = S_MLO;
                    end
                    CMD_BP:
                    begin
                        cmd.bp_update = 1'b1;
                        state_next    = S_DONE;
                    end
                    CMD_REFILL: state_next = S_MLO;
                    default:    state_next = S_DONE;
                endcase
            end
            S_MLO:
            begin
                if (status.skip)
                begin
                    state_next = after_bucket;
                    idx_next   = after_idx;
                end
                else
                begin
                    cmd.mul_lo = 1'b1;
                    state_next = S_MHI;
                end
            end
            S_MHI:
            begin
                cmd.mul_hi = 1'b1;
                step_next  = 4'd0;
                state_next = S_DIV;
            end
            // alternate digit estimate and digit fix-up
            S_DIV:
            begin
                cmd.div_est = !step_reg[0];
                cmd.div_fix = step_reg[0];
                step_next   = step_reg + 4'd1;
                if (step_reg == DIV_LAST)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = after_bucket;
                idx_next   = after_idx;
            end
            S_CHK:
            begin
                cmd.deduct = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= 2'd0;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

/* design/flow_token_bucket_backpressure.sv */
// Top level of the token bucket limiter with backpressure gate.
// Depends on ftb_pkg, ftb_ctrl and ftb_dp.
//
//   channel  | signals                         | direction
//   input    | in_valid, in_stall, in_item     | item in
//   output   | out_valid, out_stall, out_item  | result out
//   config   | cfg_we, cfg_index, cfg_data     | register write
//
// A backpressure update, a disabled or throttled check and an unused command
// go from decide straight to done. A refill or a passing check runs the four
// buckets one after another through shared multiply and divide-by-1e9 logic,
// whose divider settles eleven quotient bits per digit by an estimate and a
// fix-up step; a bucket that gains no time is skipped past. Reset loads the
// buckets at once, no sweep.
// A stalled result holds in the output register; the next item is taken
// meanwhile and finishes once that register frees.
`default_nettype none
module flow_token_bucket_backpressure import ftb_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_item,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ftb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ftb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire
